### design/scst_pkg.sv
package scst_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int SUM_W       = PROD_W + 1;
    localparam int CFG_INDEX_W = 2;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]      diff_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [SUM_W-1:0]       sum_t;
    typedef logic [CFG_INDEX_W-1:0]        cfg_index_t;

    localparam sum_t SUM_ZERO = '0;

    // Register map
    localparam cfg_index_t REG_QUERY_START_X = 2'd0;
    localparam cfg_index_t REG_QUERY_START_Y = 2'd1;
    localparam cfg_index_t REG_QUERY_END_X   = 2'd2;
    localparam cfg_index_t REG_QUERY_END_Y   = 2'd3;

    typedef enum logic [1:0] {
        CODE_NONE    = 2'd0,
        CODE_PROPER  = 2'd1,
        CODE_TOUCH   = 2'd2,
        CODE_OVERLAP = 2'd3
    } code_t;

    typedef struct packed {
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
    } segment_t;

    // Operand differences; a = query start, b = query end, c/d = segment ends
    typedef struct packed {
        diff_t bax;
        diff_t bay;
        diff_t dcx;
        diff_t dcy;
        diff_t acx;
        diff_t acy;
        logic  overlap_ok;
        logic  last;
    } prep_t;

    typedef struct packed {
        prod_t den_a;
        prod_t den_b;
        prod_t ns_a;
        prod_t ns_b;
        prod_t nt_a;
        prod_t nt_b;
        logic  overlap_ok;
        logic  last;
    } products_t;

    typedef struct packed {
        sum_t den;
        sum_t ns;
        sum_t nt;
        logic overlap_ok;
        logic last;
    } terms_t;

endpackage

### design/scst_prep.sv
module scst_prep (
    input  logic               clk,
    input  logic               rst_n,
    input  scst_pkg::segment_t query,
    input  logic               in_valid,
    output logic               in_ready,
    input  scst_pkg::segment_t seg,
    input  logic               last_segment,
    output logic               out_valid,
    input  logic               out_ready,
    output scst_pkg::prep_t    out_data
);
    import scst_pkg::*;

    // c lies within the closed extent of p..q (collinearity assumed)
    function automatic logic on_span(coord_t px, coord_t py, coord_t qx, coord_t qy,
                                     coord_t cx, coord_t cy);
        logic r;
        if (px != qx)
        begin
            r = (px <= cx && cx <= qx) || (px >= cx && cx >= qx);
        end
        else
        begin
            r = (py <= cy && cy <= qy) || (py >= cy && cy >= qy);
        end
        return r;
    endfunction

    logic  valid_reg;
    prep_t data_reg;
    prep_t data_next;
    logic  load;
    logic  degen_query;
    logic  degen_seg;
    logic  any_span;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        degen_query = (query.sx == query.ex) && (query.sy == query.ey);
        degen_seg   = (seg.sx == seg.ex) && (seg.sy == seg.ey);
        any_span    = on_span(query.sx, query.sy, query.ex, query.ey, seg.sx, seg.sy)
                   || on_span(query.sx, query.sy, query.ex, query.ey, seg.ex, seg.ey)
                   || on_span(seg.sx, seg.sy, seg.ex, seg.ey, query.sx, query.sy)
                   || on_span(seg.sx, seg.sy, seg.ex, seg.ey, query.ex, query.ey);

        data_next.bax        = diff_t'(query.ex) - diff_t'(query.sx);
        data_next.bay        = diff_t'(query.ey) - diff_t'(query.sy);
        data_next.dcx        = diff_t'(seg.ex) - diff_t'(seg.sx);
        data_next.dcy        = diff_t'(seg.ey) - diff_t'(seg.sy);
        data_next.acx        = diff_t'(query.sx) - diff_t'(seg.sx);
        data_next.acy        = diff_t'(query.sy) - diff_t'(seg.sy);
        data_next.overlap_ok = !degen_query && !degen_seg && any_span;
        data_next.last       = last_segment;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### design/scst_prod.sv
module scst_prod (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  scst_pkg::prep_t    in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output scst_pkg::terms_t   out_data
);
    import scst_pkg::*;

    logic      prod_valid_reg;
    products_t prod_reg;
    products_t prod_next;
    logic      sum_valid_reg;
    terms_t    sum_reg;
    terms_t    sum_next;
    logic      prod_en;
    logic      sum_en;
    diff_t     bax, bay, dcx, dcy, acx, acy;
    prod_t     den_a, den_b, ns_a, ns_b, nt_a, nt_b;

    assign sum_en   = !sum_valid_reg || out_ready;
    assign prod_en  = !prod_valid_reg || sum_en;
    assign in_ready = prod_en;

    // den = dcx*bay - bax*dcy, ns = acx*dcy - acy*dcx, nt = bay*acx - bax*acy
    always_comb
    begin
        bax = in_data.bax;
        bay = in_data.bay;
        dcx = in_data.dcx;
        dcy = in_data.dcy;
        acx = in_data.acx;
        acy = in_data.acy;
        prod_next.den_a      = prod_t'(dcx) * prod_t'(bay);
        prod_next.den_b      = prod_t'(bax) * prod_t'(dcy);
        prod_next.ns_a       = prod_t'(acx) * prod_t'(dcy);
        prod_next.ns_b       = prod_t'(acy) * prod_t'(dcx);
        prod_next.nt_a       = prod_t'(bay) * prod_t'(acx);
        prod_next.nt_b       = prod_t'(bax) * prod_t'(acy);
        prod_next.overlap_ok = in_data.overlap_ok;
        prod_next.last       = in_data.last;
    end

    always_comb
    begin
        den_a = prod_reg.den_a;
        den_b = prod_reg.den_b;
        ns_a  = prod_reg.ns_a;
        ns_b  = prod_reg.ns_b;
        nt_a  = prod_reg.nt_a;
        nt_b  = prod_reg.nt_b;
        sum_next.den        = sum_t'(den_a) - sum_t'(den_b);
        sum_next.ns         = sum_t'(ns_a) - sum_t'(ns_b);
        sum_next.nt         = sum_t'(nt_a) - sum_t'(nt_b);
        sum_next.overlap_ok = prod_reg.overlap_ok;
        sum_next.last       = prod_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end
        else
        begin
            if (prod_en)
            begin
                prod_valid_reg <= in_valid;
            end
            if (sum_en)
            begin
                sum_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_en && in_valid)
        begin
            prod_reg <= prod_next;
        end
        if (sum_en && prod_valid_reg)
        begin
            sum_reg <= sum_next;
        end
    end

    assign out_valid = sum_valid_reg;
    assign out_data  = sum_reg;

endmodule

### design/scst_decide.sv
module scst_decide (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  scst_pkg::terms_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       pair_code,
    output logic [1:0]       first_hit_code,
    output logic             set_done
);
    import scst_pkg::*;

    logic  out_valid_reg;
    code_t pair_code_reg;
    code_t first_hit_reg;
    logic  set_done_reg;
    code_t hit_latch_reg;
    code_t hit_latch_next;
    code_t code_next;
    code_t first_next;
    logic  load;
    sum_t  den, ns, nt;
    logic  den_pos;
    logic  touch;
    logic  inside_s, inside_t;
    logic  outside_s, outside_t;

    assign in_ready = !out_valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        den     = in_data.den;
        ns      = in_data.ns;
        nt      = in_data.nt;
        den_pos = den > SUM_ZERO;
        touch   = (ns == SUM_ZERO) || (ns == den) || (nt == SUM_ZERO) || (nt == den);
        // sign of den folded into the compares instead of negating
        inside_s  = den_pos ? (ns > SUM_ZERO && ns < den) : (ns < SUM_ZERO && ns > den);
        inside_t  = den_pos ? (nt > SUM_ZERO && nt < den) : (nt < SUM_ZERO && nt > den);
        outside_s = den_pos ? (ns < SUM_ZERO || ns > den) : (ns > SUM_ZERO || ns < den);
        outside_t = den_pos ? (nt < SUM_ZERO || nt > den) : (nt > SUM_ZERO || nt < den);

        code_next = CODE_NONE;
        if (den == SUM_ZERO)
        begin
            // parallel: nt doubles as the collinearity area term
            if (in_data.overlap_ok && nt == SUM_ZERO)
            begin
                code_next = CODE_OVERLAP;
            end
        end
        else if (inside_s && inside_t)
        begin
            code_next = CODE_PROPER;
        end
        else if (outside_s || outside_t)
        begin
            code_next = CODE_NONE;
        end
        else if (touch)
        begin
            code_next = CODE_TOUCH;
        end

        first_next     = (hit_latch_reg == CODE_NONE) ? code_next : hit_latch_reg;
        hit_latch_next = in_data.last ? CODE_NONE : first_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            hit_latch_reg <= CODE_NONE;
        end
        else
        begin
            if (in_ready)
            begin
                out_valid_reg <= in_valid;
            end
            if (load)
            begin
                hit_latch_reg <= hit_latch_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pair_code_reg <= code_next;
            first_hit_reg <= first_next;
            set_done_reg  <= in_data.last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign pair_code      = pair_code_reg;
    assign first_hit_code = first_hit_reg;
    assign set_done       = set_done_reg;

    a_first_zero_implies_none: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && first_hit_reg == CODE_NONE |-> pair_code_reg == CODE_NONE)
        else $error("first hit code empty while pair code is set");

    a_latch_follows_result: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> hit_latch_reg == (set_done_reg ? CODE_NONE : first_hit_reg))
        else $error("hit latch out of step with reported first hit");

    a_latch_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        load && hit_latch_reg != CODE_NONE && !in_data.last |=>
        hit_latch_reg == $past(hit_latch_reg))
        else $error("nonzero hit latch overwritten inside a set");

    a_parallel_codes: assert property (@(posedge clk) disable iff (!rst_n)
        load && in_data.den == SUM_ZERO |->
        code_next != CODE_PROPER && code_next != CODE_TOUCH)
        else $error("crossing code for parallel segments");

endmodule

### design/segment_set_crossing_test.sv
// Segment set crossing test. The query segment is loaded through the
// configuration channel (index 0 start x, 1 start y, 2 end x, 3 end y,
// signed 16-bit, all zero after reset) and may only be rewritten while no
// request is in flight. Each input request carries one segment of a set and
// yields exactly one result: pair_code (0 no contact, 1 proper crossing,
// 2 endpoint touch, 3 collinear overlap), first_hit_code (first nonzero
// code of the set so far, else 0) and set_done (copy of last_segment; the
// latched first hit is cleared after that request). All arithmetic is
// exact integer math, so there are no tolerance effects. Throughput is one
// request per clock while the output is not stalled; the result passes
// through four register stages: operand differences, 17x17
// products, cross terms, and the classified result. Each stage holds its
// request while downstream stalls, so input keeps flowing until the stages
// fill.
module segment_set_crossing_test (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  scst_pkg::cfg_index_t         cfg_index,
    input  logic [scst_pkg::COORD_WIDTH-1:0] cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  scst_pkg::coord_t             seg_start_x,
    input  scst_pkg::coord_t             seg_start_y,
    input  scst_pkg::coord_t             seg_end_x,
    input  scst_pkg::coord_t             seg_end_y,
    input  logic                         last_segment,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   pair_code,
    output logic [1:0]                   first_hit_code,
    output logic                         set_done
);
    import scst_pkg::*;

    segment_t query_reg;
    segment_t query_next;
    segment_t seg;
    prep_t    prep_data;
    logic     prep_valid;
    logic     prep_ready;
    terms_t   terms_data;
    logic     terms_valid;
    logic     terms_ready;

    // Config writes are always taken
    assign cfg_ready = 1'b1;

    always_comb
    begin
        query_next = query_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_QUERY_START_X: query_next.sx = coord_t'(cfg_data);
                REG_QUERY_START_Y: query_next.sy = coord_t'(cfg_data);
                REG_QUERY_END_X:   query_next.ex = coord_t'(cfg_data);
                REG_QUERY_END_Y:   query_next.ey = coord_t'(cfg_data);
                default:           query_next = query_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_reg <= '0;
        end
        else
        begin
            query_reg <= query_next;
        end
    end

    assign seg.sx = seg_start_x;
    assign seg.sy = seg_start_y;
    assign seg.ex = seg_end_x;
    assign seg.ey = seg_end_y;

    // Stage 1: differences, degenerate and span flags
    scst_prep u_prep (
        .clk          (clk),
        .rst_n        (rst_n),
        .query        (query_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .seg          (seg),
        .last_segment (last_segment),
        .out_valid    (prep_valid),
        .out_ready    (prep_ready),
        .out_data     (prep_data)
    );

    // Stages 2-3: products, then den / ns / nt
    scst_prod u_prod (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_data   (prep_data),
        .out_valid (terms_valid),
        .out_ready (terms_ready),
        .out_data  (terms_data)
    );

    // Stage 4: classification, first-hit latch, result register
    scst_decide u_decide (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (terms_valid),
        .in_ready       (terms_ready),
        .in_data        (terms_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pair_code      (pair_code),
        .first_hit_code (first_hit_code),
        .set_done       (set_done)
    );

endmodule

### dv/testbench.sv
// Testbench for segment_set_crossing_test.
//
// A driver feeds segment requests from a queue that the stimulus block fills,
// with bursts and random gaps. A monitor samples the input, output and config
// handshakes at the rising edge. It keeps its own copy of the query segment,
// predicts each accepted request's codes, and compares each result against
// the oldest prediction. The receiver stalls on its own pattern, and once, asked by
// the stimulus block, holds off long enough that the pipeline fills and in_ready drops.
module testbench;
    import scst_pkg::*;

    localparam int HOLD_CYCLES    = 150;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_REQUESTS = 100;
    localparam int DRAIN_CYCLES   = 12;

    typedef struct packed {
        segment_t seg;
        logic     last;
    } seg_req_t;

    typedef struct packed {
        code_t pair;
        code_t first;
        logic  done;
    } pair_result_t;

    // coordinate flavors for random picks
    typedef enum int {PICK_SMALL, PICK_FULL, PICK_EXTREME} pick_t;

    // receiver stall patterns
    typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    cfg_index_t cfg_index = REG_QUERY_START_X;
    logic [COORD_WIDTH-1:0] cfg_data = '0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    coord_t     seg_start_x = '0;
    coord_t     seg_start_y = '0;
    coord_t     seg_end_x = '0;
    coord_t     seg_end_y = '0;
    logic       last_segment = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] pair_code;
    logic [1:0] first_hit_code;
    logic       set_done;

    segment_t     query_shadow = '0;      // monitor's copy of the query registers
    code_t        set_first_hit = CODE_NONE;
    seg_req_t     pending_segments[$];
    pair_result_t expected_results[$];
    coord_t       query_plan[4] = '{default: '0};  // query the generator aims at
    int           mismatch_count = 0;
    int           results_seen = 0;

    int       burst_left = 0;
    int       gap_left = 0;
    int       hold_ask = 0;
    int       hold_seen = 0;
    int       hold_left = 0;
    rx_mode_t rx_mode = RX_STEADY;
    int       mode_left = 0;
    logic [7:0] rx_pattern = 8'hff;

    segment_set_crossing_test dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .seg_start_x    (seg_start_x),
        .seg_start_y    (seg_start_y),
        .seg_end_x      (seg_end_x),
        .seg_end_y      (seg_end_y),
        .last_segment   (last_segment),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pair_code      (pair_code),
        .first_hit_code (first_hit_code),
        .set_done       (set_done)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    // Closed extent test for a point already known to be collinear; x decides
    // unless p-q is vertical.
    function automatic bit on_span(input longint px, py, qx, qy, cx, cy);
        if (px != qx)
            return (px <= cx && cx <= qx) || (px >= cx && cx >= qx);
        return (py <= cy && cy <= qy) || (py >= cy && cy >= qy);
    endfunction

    // Exact classification of segment c-d against query a-b. Products stay
    // within about 35 bits, so longint holds every term.
    function automatic code_t crossing_code(input longint ax, ay, bx, by,
                                            cx, cy, dx, dy);
        longint den;
        longint ns;
        longint nt;
        longint area;
        code_t  code;
        code = CODE_NONE;
        den = ax * (dy - cy) + bx * (cy - dy) + dx * (by - ay) + cx * (ay - by);
        if (den == 0)
        begin
            // parallel: a point on either side never counts
            if ((ax == bx && ay == by) || (cx == dx && cy == dy))
                return CODE_NONE;
            area = (bx - ax) * (cy - ay) - (cx - ax) * (by - ay);
            if (area != 0)
                return CODE_NONE;
            if (on_span(ax, ay, bx, by, cx, cy) || on_span(ax, ay, bx, by, dx, dy) ||
                on_span(cx, cy, dx, dy, ax, ay) || on_span(cx, cy, dx, dy, bx, by))
                return CODE_OVERLAP;
            return CODE_NONE;
        end
        ns = ax * (dy - cy) + cx * (ay - dy) + dx * (cy - ay);
        nt = -(ax * (cy - by) + bx * (ay - cy) + cx * (by - ay));
        // parameter exactly 0 or 1 on either segment: endpoint touch
        if (ns == 0 || ns == den || nt == 0 || nt == den)
            code = CODE_TOUCH;
        if (den < 0)
        begin
            den = -den;
            ns  = -ns;
            nt  = -nt;
        end
        if (ns > 0 && ns < den && nt > 0 && nt < den)
            code = CODE_PROPER;
        else if (ns < 0 || ns > den || nt < 0 || nt > den)
            code = CODE_NONE;
        return code;
    endfunction

    task automatic report_mismatch(input string msg);
        // keep the log bounded when the block is badly broken
        if (mismatch_count < 100)
            $display("mismatch at result %0d: %s", results_seen, msg);
        mismatch_count++;
    endtask

    // ---------------------------------------------------------------- driver

    // One request per burst slot; valid and payload hold until accepted.
    always @(posedge clk)
    begin : drive_proc
        seg_req_t req;
        logic     next_valid;
        if (rst_n && !(in_valid && !in_ready))
        begin
            next_valid = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (pending_segments.size() > 0)
            begin
                req = pending_segments.pop_front();
                next_valid = 1'b1;
                seg_start_x  <= req.seg.sx;
                seg_start_y  <= req.seg.sy;
                seg_end_x    <= req.seg.ex;
                seg_end_y    <= req.seg.ey;
                last_segment <= req.last;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            in_valid <= next_valid;
        end
    end

    // ---------------------------------------------------------------- receiver

    // A hold-off asked by the stimulus block wins; otherwise the ready pattern
    // switches between randomly chosen modes.
    always @(posedge clk)
    begin : receive_proc
        logic rdy;
        rdy = 1'b1;
        if (hold_left > 0)
        begin
            hold_left--;
            rdy = 1'b0;
        end
        else if (hold_seen != hold_ask)
        begin
            hold_seen = hold_ask;
            hold_left = HOLD_CYCLES;
            rdy = 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 80);
                rx_pattern = 8'($urandom);
            end
            else
                mode_left--;
            case (rx_mode)
                RX_STEADY: rdy = 1'b1;
                RX_COIN:   rdy = 1'($urandom_range(0, 1));
                RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
                default:
                begin
                    rdy = rx_pattern[0];
                    rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
                end
            endcase
        end
        out_ready <= rdy;
    end

    // ---------------------------------------------------------------- monitor

    // Results are checked before new requests are predicted, so a result can
    // never be matched against a request accepted at the same edge.
    always @(posedge clk)
    begin : monitor_proc
        pair_result_t want;
        code_t        code;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("result with no request pending, pair %0d",
                                              pair_code));
                else
                begin
                    want = expected_results.pop_front();
                    if (pair_code !== want.pair)
                        report_mismatch($sformatf("pair_code %0d, want %0d",
                                                  pair_code, want.pair));
                    if (first_hit_code !== want.first)
                        report_mismatch($sformatf("first_hit_code %0d, want %0d",
                                                  first_hit_code, want.first));
                    if (set_done !== want.done)
                        report_mismatch($sformatf("set_done %0d, want %0d",
                                                  set_done, want.done));
                end
                results_seen++;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_QUERY_START_X: query_shadow.sx = cfg_data;
                    REG_QUERY_START_Y: query_shadow.sy = cfg_data;
                    REG_QUERY_END_X:   query_shadow.ex = cfg_data;
                    REG_QUERY_END_Y:   query_shadow.ey = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                code = crossing_code(query_shadow.sx, query_shadow.sy,
                                     query_shadow.ex, query_shadow.ey,
                                     seg_start_x, seg_start_y, seg_end_x, seg_end_y);
                // first nonzero code of the set sticks until the set closes
                if (set_first_hit == CODE_NONE)
                    set_first_hit = code;
                want.pair  = code;
                want.first = set_first_hit;
                want.done  = last_segment;
                expected_results.push_back(want);
                if (last_segment)
                    set_first_hit = CODE_NONE;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic cfg_write(input cfg_index_t idx, input coord_t val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Only called with the pipeline empty. Ends on a falling edge so the
    // queue is filled away from the driver's edge.
    task automatic load_query(input coord_t ax, ay, bx, by);
        cfg_write(REG_QUERY_START_X, ax);
        cfg_write(REG_QUERY_START_Y, ay);
        cfg_write(REG_QUERY_END_X, bx);
        cfg_write(REG_QUERY_END_Y, by);
        query_plan[0] = ax;
        query_plan[1] = ay;
        query_plan[2] = bx;
        query_plan[3] = by;
        @(negedge clk);
    endtask

    task automatic push_segment(input coord_t sx, sy, ex, ey, input logic last);
        seg_req_t req;
        req.seg.sx = sx;
        req.seg.sy = sy;
        req.seg.ex = ex;
        req.seg.ey = ey;
        req.last = last;
        pending_segments.push_back(req);
    endtask

    // Nothing queued, nothing on the wire, nothing outstanding.
    task automatic wait_drained();
        do @(negedge clk);
        while (pending_segments.size() != 0 || in_valid || expected_results.size() != 0);
    endtask

    function automatic coord_t pick_coord(input pick_t mode);
        int v;
        case (mode)
            PICK_SMALL:
            begin
                v = $urandom_range(0, 16);
                v = v - 8;
            end
            PICK_FULL: v = $urandom;
            default:
            begin
                case ($urandom_range(0, 5))
                    0: v = -32768;
                    1: v = 32767;
                    2: v = 0;
                    3: v = -1;
                    4: v = 1;
                    default: v = -32767;
                endcase
            end
        endcase
        return coord_t'(v);
    endfunction

    // Random segment, mostly shaped around the current query so that
    // crossings, touches and collinear cases turn up often.
    function automatic seg_req_t make_segment();
        seg_req_t req;
        int       k1;
        int       k2;
        int       qdx;
        int       qdy;
        int       v;
        qdx = int'(query_plan[2]) - int'(query_plan[0]);
        qdy = int'(query_plan[3]) - int'(query_plan[1]);
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                req.seg.sx = pick_coord(PICK_SMALL);
                req.seg.sy = pick_coord(PICK_SMALL);
                req.seg.ex = pick_coord(PICK_SMALL);
                req.seg.ey = pick_coord(PICK_SMALL);
            end
            4:
            begin
                // shares an endpoint with the query
                v = $urandom_range(0, 1) * 2;
                req.seg.sx = query_plan[v];
                req.seg.sy = query_plan[v + 1];
                req.seg.ex = query_plan[v] + pick_coord(PICK_SMALL);
                req.seg.ey = query_plan[v + 1] + pick_coord(PICK_SMALL);
            end
            5:
            begin
                // endpoints on the query's line at whole steps
                k1 = $urandom_range(0, 5);
                k1 = k1 - 2;
                k2 = $urandom_range(0, 5);
                k2 = k2 - 2;
                req.seg.sx = coord_t'(int'(query_plan[0]) + k1 * qdx);
                req.seg.sy = coord_t'(int'(query_plan[1]) + k1 * qdy);
                req.seg.ex = coord_t'(int'(query_plan[0]) + k2 * qdx);
                req.seg.ey = coord_t'(int'(query_plan[1]) + k2 * qdy);
            end
            6:
            begin
                // single point
                req.seg.sx = pick_coord(PICK_SMALL);
                req.seg.sy = pick_coord(PICK_SMALL);
                req.seg.ex = req.seg.sx;
                req.seg.ey = req.seg.sy;
            end
            7:
            begin
                req.seg.sx = pick_coord(PICK_FULL);
                req.seg.sy = pick_coord(PICK_FULL);
                req.seg.ex = pick_coord(PICK_FULL);
                req.seg.ey = pick_coord(PICK_FULL);
            end
            8:
            begin
                req.seg.sx = pick_coord(PICK_EXTREME);
                req.seg.sy = pick_coord(PICK_EXTREME);
                req.seg.ex = pick_coord(PICK_EXTREME);
                req.seg.ey = pick_coord(PICK_EXTREME);
            end
            default:
            begin
                // the query itself, either direction
                v = $urandom_range(0, 1) * 2;
                req.seg.sx = query_plan[v];
                req.seg.sy = query_plan[v + 1];
                req.seg.ex = query_plan[2 - v];
                req.seg.ey = query_plan[3 - v];
            end
        endcase
        req.last = ($urandom_range(0, 4) == 0);
        return req;
    endfunction

    initial
    begin : stimulus_proc
        int     p;
        int     i;
        pick_t  mode;
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset query is a single point at the origin: never any contact
        push_segment(0, 0, 0, 0, 1'b0);
        push_segment(-5, 0, 5, 0, 1'b1);
        wait_drained();

        // horizontal query: each code, latch hold and clear, parallel cases
        load_query(-100, 0, 100, 0);
        push_segment(0, -50, 0, 50, 1'b0);     // proper crossing
        push_segment(0, 0, 0, 50, 1'b0);       // endpoint on query
        push_segment(100, 0, 100, 20, 1'b0);   // query end on segment
        push_segment(0, 10, 0, 50, 1'b1);      // misses, closes set
        push_segment(50, 0, 200, 0, 1'b0);     // collinear overlap
        push_segment(200, 0, 300, 0, 1'b1);    // collinear, disjoint
        push_segment(0, 5, 10, 5, 1'b0);       // parallel off the line
        push_segment(7, 0, 7, 0, 1'b1);        // single-point segment
        push_segment(-100, 0, 100, 0, 1'b1);   // one-request set
        wait_drained();

        // full-range diagonal query
        load_query(-32768, -32768, 32767, 32767);
        push_segment(-32768, 32767, 32767, -32768, 1'b0);
        push_segment(-32768, -32768, -32768, 32767, 1'b0);
        push_segment(0, 0, 32767, 32767, 1'b1);
        push_segment(32767, 32767, 32767, 32767, 1'b1);
        push_segment(32767, -32768, -1, -1, 1'b1);
        wait_drained();

        // vertical query: overlap decided on y
        load_query(5, -32768, 5, 32767);
        push_segment(5, 100, 5, 200, 1'b0);
        push_segment(6, 0, 6, 10, 1'b0);
        push_segment(0, 0, 10, 0, 1'b0);
        push_segment(5, 0, 20, 7, 1'b1);
        wait_drained();

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            mode = (p == 2) ? PICK_FULL : (p == 5) ? PICK_EXTREME : PICK_SMALL;
            ax = pick_coord(mode);
            ay = pick_coord(mode);
            bx = pick_coord(mode);
            by = pick_coord(mode);
            if (p == 3)
                by = ay;    // horizontal
            if (p == 4)
                bx = ax;    // vertical
            load_query(ax, ay, bx, by);
            // long receiver hold-off while the sender keeps pushing
            if (p == 1)
                hold_ask++;
            for (i = 0; i < PHASE_REQUESTS; i++)
                pending_segments.push_back(make_segment());
            wait_drained();
        end

        // allow a stray late result to show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #400000;
        $display("status: fail");
        $finish;
    end
endmodule
